>>> hw/rtl/svad_pkg.sv
// svad_pkg: shared constants, codes and types for the sparse vector add/dot block.
// No dependencies; svad_mac and the top level refer to it by scoped names.
`timescale 1ns / 1ps

package svad_pkg;

   // vector geometry
   localparam int DIM    = 32;
   localparam int ADDR_W = (DIM > 1) ? $clog2(DIM) : 1;

   // field widths
   localparam int CMD_W  = 2;
   localparam int POS_W  = 5;
   localparam int VAL_W  = 16;
   localparam int SUM_W  = 17;
   localparam int PROD_W = 32;
   localparam int DOT_W  = 37;

   // command codes
   localparam logic [CMD_W-1:0] CMD_WRITE_A = 2'd0;
   localparam logic [CMD_W-1:0] CMD_WRITE_B = 2'd1;
   localparam logic [CMD_W-1:0] CMD_CLEAR   = 2'd2;
   localparam logic [CMD_W-1:0] CMD_COMPUTE = 2'd3;

   // result kinds
   localparam logic KIND_SUM = 1'b0;
   localparam logic KIND_DOT = 1'b1;

   // controls for the multiply-accumulate pipe
   typedef struct packed {
      logic clear;  // start of a compute run, zero the accumulator
      logic vld;    // a walked position sits in stage one
      logic last;   // that position is the final one
      logic both;   // present in both vectors, product counts
   } mac_ctrl_type;

endpackage

>>> hw/rtl/svad_ram.sv
// svad_ram: generic single-write, single-read synchronous RAM with a registered read port.
// No dependencies; the entries hold no reset value.
`timescale 1ns / 1ps

module svad_ram #(
   parameter int DEPTH  = 32,
   parameter int WIDTH  = 16,
   parameter int ADDR_W = 5
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/svad_mac.sv
// svad_mac: registered 16x16 multiply followed by a 37-bit accumulator.
// Depends on svad_pkg for widths and the mac_ctrl_type control struct.
`timescale 1ns / 1ps

module svad_mac (
   input  logic                              clock,
   input  logic                              reset,
   input  svad_pkg::mac_ctrl_type            ctrl,
   input  logic signed [svad_pkg::VAL_W-1:0] a_val,
   input  logic signed [svad_pkg::VAL_W-1:0] b_val,
   output logic                              dot_vld,
   output logic signed [svad_pkg::DOT_W-1:0] dot_value
);

   logic signed [svad_pkg::PROD_W-1:0] prod_ff, prod_in;
   logic signed [svad_pkg::DOT_W-1:0]  acc_ff, acc_in;
   logic                               s2_vld_ff, s2_vld_in;
   logic                               s2_last_ff, s2_last_in;
   logic signed [svad_pkg::DOT_W-1:0]  total;

   // running total including the product now in stage two
   assign total = acc_ff + svad_pkg::DOT_W'(prod_ff);

   always_comb begin
      // keep the multiply in a signed context so both operands sign-extend
      prod_in = '0;
      if (ctrl.both) begin
         prod_in = a_val * b_val;
      end
      s2_vld_in  = ctrl.vld;
      s2_last_in = ctrl.last;
      acc_in     = acc_ff;
      if (ctrl.clear) begin
         acc_in = '0;
      end else if (s2_vld_ff) begin
         acc_in = total;
      end
   end

   // control flags reset; datapath registers hold no reset
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff  <= 1'b0;
         s2_last_ff <= 1'b0;
      end else begin
         s2_vld_ff  <= s2_vld_in;
         s2_last_ff <= s2_last_in;
      end
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

   assign dot_vld   = s2_vld_ff && s2_last_ff;
   assign dot_value = total;

endmodule

>>> hw/rtl/sparse_vector_add_dot_top.sv
// A compute item walks every position of the value RAMs in order; the result register gets
// a sum entry for each position present in either vector, then the dot product once the
// multiply and accumulate stages have drained. Busy stays high from the walk until the dot
// product leaves the accumulator, and no new item is accepted meanwhile; write and clear
// items leave busy low.
// Reset clears the presence bits, sequencer state and valid flags at once; the value RAMs
// keep their contents, used only where a presence bit is set. Results cannot be stalled.
`timescale 1ns / 1ps

module sparse_vector_add_dot_top (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   output logic                                   busy,
   input  logic [svad_pkg::CMD_W-1:0]             req_command,
   input  logic [svad_pkg::POS_W-1:0]             req_position,
   input  logic signed [svad_pkg::VAL_W-1:0]      req_element_value,
   output logic                                   rsp_valid,
   output logic                                   rsp_kind,
   output logic [svad_pkg::POS_W-1:0]             rsp_entry_position,
   output logic signed [svad_pkg::SUM_W-1:0]      rsp_sum_value,
   output logic signed [svad_pkg::DOT_W-1:0]      rsp_dot_value,
   output logic                                   rsp_last
);

   typedef enum logic [1:0] {ST_IDLE, ST_WALK, ST_FLUSH} state_type;

   state_type                            state_ff, state_in;
   logic [svad_pkg::ADDR_W-1:0]          idx_ff, idx_in;
   logic [svad_pkg::DIM-1:0]             present_a_ff, present_a_in;
   logic [svad_pkg::DIM-1:0]             present_b_ff, present_b_in;
   logic                                 s1_vld_ff, s1_vld_in;
   logic                                 s1_last_ff, s1_last_in;
   logic                                 s1_pa_ff, s1_pa_in;
   logic                                 s1_pb_ff, s1_pb_in;
   logic [svad_pkg::ADDR_W-1:0]          s1_idx_ff, s1_idx_in;
   logic                                 rsp_valid_ff, rsp_valid_in;
   logic                                 rsp_kind_ff, rsp_kind_in;
   logic                                 rsp_last_ff, rsp_last_in;
   logic [svad_pkg::POS_W-1:0]           rsp_pos_ff, rsp_pos_in;
   logic signed [svad_pkg::SUM_W-1:0]    rsp_sum_ff, rsp_sum_in;
   logic signed [svad_pkg::DOT_W-1:0]    rsp_dot_ff, rsp_dot_in;

   logic                                 accept;
   logic                                 in_range;
   logic [svad_pkg::ADDR_W-1:0]          wr_addr;
   logic                                 wr_a_en, wr_b_en;
   logic                                 rd_en;
   logic                                 idx_at_end;
   logic [svad_pkg::VAL_W-1:0]           rd_a, rd_b;
   logic signed [svad_pkg::VAL_W-1:0]    a_val, b_val;
   svad_pkg::mac_ctrl_type               mac_ctrl;
   logic                                 dot_vld;
   logic signed [svad_pkg::DOT_W-1:0]    dot_value;

   // input transfer decode
   assign busy       = (state_ff != ST_IDLE);
   assign accept     = start && !busy;
   assign in_range   = (int'(req_position) < svad_pkg::DIM);
   assign wr_addr    = svad_pkg::ADDR_W'(req_position);
   assign wr_a_en    = accept && (req_command == svad_pkg::CMD_WRITE_A) && in_range;
   assign wr_b_en    = accept && (req_command == svad_pkg::CMD_WRITE_B) && in_range;
   assign rd_en      = (state_ff == ST_WALK);
   assign idx_at_end = (idx_ff == svad_pkg::ADDR_W'(svad_pkg::DIM - 1));

   svad_ram #(
      .DEPTH  (svad_pkg::DIM),
      .WIDTH  (svad_pkg::VAL_W),
      .ADDR_W (svad_pkg::ADDR_W)
   ) u_ram_a (
      .clock   (clock),
      .wr_en   (wr_a_en),
      .wr_addr (wr_addr),
      .wr_data (req_element_value),
      .rd_en   (rd_en),
      .rd_addr (idx_ff),
      .rd_data (rd_a)
   );

   svad_ram #(
      .DEPTH  (svad_pkg::DIM),
      .WIDTH  (svad_pkg::VAL_W),
      .ADDR_W (svad_pkg::ADDR_W)
   ) u_ram_b (
      .clock   (clock),
      .wr_en   (wr_b_en),
      .wr_addr (wr_addr),
      .wr_data (req_element_value),
      .rd_en   (rd_en),
      .rd_addr (idx_ff),
      .rd_data (rd_b)
   );

   // stage one: mask absent entries to zero
   assign a_val = s1_pa_ff ? $signed(rd_a) : '0;
   assign b_val = s1_pb_ff ? $signed(rd_b) : '0;

   assign mac_ctrl.clear = accept && (req_command == svad_pkg::CMD_COMPUTE);
   assign mac_ctrl.vld   = s1_vld_ff;
   assign mac_ctrl.last  = s1_last_ff;
   assign mac_ctrl.both  = s1_vld_ff && s1_pa_ff && s1_pb_ff;

   svad_mac u_mac (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (mac_ctrl),
      .a_val     (a_val),
      .b_val     (b_val),
      .dot_vld   (dot_vld),
      .dot_value (dot_value)
   );

   // sequencer, presence bits and result register next values
   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      present_a_in = present_a_ff;
      present_b_in = present_b_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_command)
                  svad_pkg::CMD_WRITE_A: begin
                     if (in_range) begin
                        present_a_in[wr_addr] = 1'b1;
                     end
                  end
                  svad_pkg::CMD_WRITE_B: begin
                     if (in_range) begin
                        present_b_in[wr_addr] = 1'b1;
                     end
                  end
                  svad_pkg::CMD_CLEAR: begin
                     present_a_in = '0;
                     present_b_in = '0;
                  end
                  default: begin
                     state_in = ST_WALK;
                     idx_in   = '0;
                  end
               endcase
            end
         end
         ST_WALK: begin
            if (idx_at_end) begin
               state_in = ST_FLUSH;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_FLUSH: begin
            if (dot_vld) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // advance the walked position into stage one
      s1_vld_in  = (state_ff == ST_WALK);
      s1_last_in = idx_at_end;
      s1_idx_in  = idx_ff;
      s1_pa_in   = present_a_ff[idx_ff];
      s1_pb_in   = present_b_ff[idx_ff];

      // result register: sum entries from stage one, dot product from the mac
      rsp_valid_in = 1'b0;
      rsp_kind_in  = svad_pkg::KIND_SUM;
      rsp_last_in  = 1'b0;
      rsp_pos_in   = '0;
      rsp_sum_in   = '0;
      rsp_dot_in   = '0;
      if (s1_vld_ff && (s1_pa_ff || s1_pb_ff)) begin
         rsp_valid_in = 1'b1;
         rsp_pos_in   = svad_pkg::POS_W'(s1_idx_ff);
         rsp_sum_in   = svad_pkg::SUM_W'(a_val) + svad_pkg::SUM_W'(b_val);
      end else if (dot_vld) begin
         rsp_valid_in = 1'b1;
         rsp_kind_in  = svad_pkg::KIND_DOT;
         rsp_last_in  = 1'b1;
         rsp_dot_in   = dot_value;
      end
   end

   // hold state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         present_a_ff <= '0;
         present_b_ff <= '0;
         s1_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         present_a_ff <= present_a_in;
         present_b_ff <= present_b_in;
         s1_vld_ff    <= s1_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff      <= idx_in;
      s1_last_ff  <= s1_last_in;
      s1_idx_ff   <= s1_idx_in;
      s1_pa_ff    <= s1_pa_in;
      s1_pb_ff    <= s1_pb_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_last_ff <= rsp_last_in;
      rsp_pos_ff  <= rsp_pos_in;
      rsp_sum_ff  <= rsp_sum_in;
      rsp_dot_ff  <= rsp_dot_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_kind           = rsp_kind_ff;
   assign rsp_last           = rsp_last_ff;
   assign rsp_entry_position = rsp_pos_ff;
   assign rsp_sum_value      = rsp_sum_ff;
   assign rsp_dot_value      = rsp_dot_ff;

   // a result marks the end of a run exactly when it carries the dot product
   a_last_is_dot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last == (rsp_kind == svad_pkg::KIND_DOT)))
      else $error("last flag disagrees with result kind");

   // an accepted compute item raises busy on the next cycle
   a_compute_busy: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_command == svad_pkg::CMD_COMPUTE)) |=> busy)
      else $error("compute transfer did not start the walk");

   // the dot product only arrives once the walk has finished
   a_dot_after_walk: assert property (@(posedge clock) disable iff (reset)
      dot_vld |-> (state_ff == ST_FLUSH))
      else $error("dot product produced outside the flush phase");

   // a sum entry and the dot product never compete for the result register
   a_no_collision: assert property (@(posedge clock) disable iff (reset)
      !(s1_vld_ff && dot_vld))
      else $error("sum entry collides with dot product");

   // the presence bits never change while a run is in flight
   a_present_stable: assert property (@(posedge clock) disable iff (reset)
      (busy && $past(busy)) |-> ($stable(present_a_ff) && $stable(present_b_ff)))
      else $error("presence bits changed during a compute run");

endmodule
